>>> src/lens_and_keystone_position_control_macros.svh
// ----------------------------------------------------------------------------
// Lens and keystone position control: assertion macros
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LENS_AND_KEYSTONE_POSITION_CONTROL_MACROS_SVH
`define LENS_AND_KEYSTONE_POSITION_CONTROL_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LKPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lkpc assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define LKPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lkpc assertion failed");

`endif

>>> src/lkpc_pkg.sv
// ----------------------------------------------------------------------------
// lkpc_pkg
// Codes, widths and reset values for the lens and keystone position control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkpc_pkg;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned SPEED_W = 7;
    localparam int unsigned DRIVE_W = 8;
    localparam int unsigned CFG_AW  = 3;
    localparam int unsigned CFG_DW  = 16;
    localparam int unsigned RAMP_KW = 20;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 40;

    // opcodes
    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_BUTTON     = 3'd1;
    localparam logic [2:0] OP_MOVE_REV   = 3'd2;
    localparam logic [2:0] OP_MOVE_FWD   = 3'd3;
    localparam logic [2:0] OP_SET_LENS   = 3'd4;
    localparam logic [2:0] OP_SET_KEY    = 3'd5;

    // buttons
    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_TOLERANCE  = 3'd0;
    localparam logic [2:0] CFG_SPEED_MIN  = 3'd1;
    localparam logic [2:0] CFG_SPEED_MAX  = 3'd2;
    localparam logic [2:0] CFG_SLOW_BAND  = 3'd3;
    localparam logic [2:0] CFG_LENS_HOME  = 3'd4;
    localparam logic [2:0] CFG_KEY_HOME   = 3'd5;
    localparam logic [2:0] CFG_STEP_SIZE  = 3'd6;

    // register reset values
    localparam logic [7:0]  RST_TOLERANCE = 8'd2;
    localparam logic [6:0]  RST_SPEED_MIN = 7'd35;
    localparam logic [6:0]  RST_SPEED_MAX = 7'd80;
    localparam logic [6:0]  RST_SLOW_BAND = 7'd20;
    localparam logic [15:0] RST_LENS_HOME = 16'd300;
    localparam logic [15:0] RST_KEY_HOME  = 16'd200;
    localparam logic [6:0]  RST_STEP_SIZE = 7'd5;

    // ramp: distance * slope / 100, division by multiply with 5243 and shift by 19
    localparam logic [15:0] FAR_DISTANCE = 16'd100;
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int unsigned RECIP_SHIFT  = 19;
    localparam logic [RAMP_KW-1:0] RST_RAMP_K =
        RAMP_KW'((int'(RST_SPEED_MAX) - int'(RST_SPEED_MIN)) * int'(RECIP_100));

endpackage

`default_nettype wire

>>> src/lens_and_keystone_position_control.sv
// A request is held in the input register, then its result in the output register.
// One request per cycle while the output is not stalled; the state update is a single registered pass.
// The output register and the input register let a request enter while a result waits.
// Reset (synchronous, active low): both axes await homing, positions and targets zero,
// drive level at the speed_max reset value, registers at their reset values.
// ----------------------------------------------------------------------------
// Lens and keystone position control
// Tracks the lens encoder position, sets the banded lens drive speed on each
// tick once the lens is homed and steps the keystone axis while the lens is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lens_and_keystone_position_control_macros.svh"

module lens_and_keystone_position_control
    import lkpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output      logic                 o_s_axis_tready,
    // button[1:0], move_amount[9:2], target_position[25:10], zero[31:26]
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // opcode[2:0]
    input  wire logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output      logic                 o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // motor_drive[7:0], stepper_steps[15:8], lens_running[16],
    // keystone_running[17], lens_position[33:18], zero[39:34]
    output      logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [CFG_DW-1:0]    i_cfg_wdata
);

    // configuration
    logic [7:0]         r_tolerance;
    logic [6:0]         r_speed_min;
    logic [6:0]         r_speed_max;
    logic [6:0]         r_slow_band;
    logic [15:0]        r_lens_home;
    logic [15:0]        r_key_home;
    logic [6:0]         r_step_size;
    logic [RAMP_KW-1:0] r_ramp_k;
    logic               r_ramp_neg;
    logic [RAMP_KW-1:0] n_ramp_k;
    logic               n_ramp_neg;

    // state
    logic               r_lens_mode, n_lens_mode;
    logic               r_key_mode, n_key_mode;
    logic [15:0]        r_lens_pos, n_lens_pos;
    logic [15:0]        r_lens_target, n_lens_target;
    logic [15:0]        r_key_pos, n_key_pos;
    logic [15:0]        r_key_target, n_key_target;
    logic [7:0]         r_drive, n_drive;

    // input register
    logic               r_in_valid;
    logic [2:0]         r_in_opcode;
    logic [1:0]         r_in_button;
    logic [7:0]         r_in_amount;
    logic [15:0]        r_in_target;

    // output register
    logic               r_out_valid;
    logic [7:0]         r_out_drive;
    logic [7:0]         r_out_steps;
    logic               r_out_lens_run;
    logic               r_out_key_run;
    logic [15:0]        r_out_lens_pos;

    logic               advance;
    logic               process;
    logic [7:0]         steps;

    logic [6:0]         cfg_min_nx;
    logic [6:0]         cfg_max_nx;
    logic [7:0]         cfg_delta;
    logic [6:0]         cfg_mag;

    logic [15:0]        lens_diff;
    logic               lens_neg;
    logic [15:0]        lens_dist;
    logic [26:0]        ramp_prod;
    logic [6:0]         ramp_q;
    logic [7:0]         ramp_spd;
    logic [7:0]         spd_mag;
    logic [7:0]         lens_spd;
    logic [15:0]        key_diff;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign process         = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    // ramp slope, kept as |max - min| * 5243 with its sign
    always_comb begin
        cfg_min_nx = r_speed_min;
        cfg_max_nx = r_speed_max;
        if (i_cfg_we && i_cfg_addr == CFG_SPEED_MIN) begin
            cfg_min_nx = i_cfg_wdata[6:0];
        end
        if (i_cfg_we && i_cfg_addr == CFG_SPEED_MAX) begin
            cfg_max_nx = i_cfg_wdata[6:0];
        end
        cfg_delta  = {1'b0, cfg_max_nx} - {1'b0, cfg_min_nx};
        n_ramp_neg = cfg_delta[7];
        cfg_mag    = cfg_delta[7] ? 7'(8'd0 - cfg_delta) : cfg_delta[6:0];
        n_ramp_k   = RAMP_KW'(cfg_mag) * RAMP_KW'(RECIP_100);
    end

    // banded speed profile
    always_comb begin
        lens_diff = r_lens_pos - r_lens_target;
        lens_neg  = lens_diff[15];
        lens_dist = lens_neg ? (16'd0 - lens_diff) : lens_diff;
        ramp_prod = 27'(lens_dist[6:0]) * 27'(r_ramp_k);
        ramp_q    = ramp_prod[RECIP_SHIFT+6:RECIP_SHIFT];
        ramp_spd  = r_ramp_neg ? ({1'b0, r_speed_min} - {1'b0, ramp_q})
                               : ({1'b0, r_speed_min} + {1'b0, ramp_q});
        if (lens_dist <= {8'd0, r_tolerance}) begin
            spd_mag = 8'd0;
        end else if (lens_dist <= {9'd0, r_slow_band}) begin
            spd_mag = {1'b0, r_speed_min};
        end else if (lens_dist > FAR_DISTANCE) begin
            spd_mag = {1'b0, r_speed_max};
        end else begin
            spd_mag = ramp_spd;
        end
        lens_spd = lens_neg ? (8'd0 - spd_mag) : spd_mag;
        key_diff = r_key_pos - r_key_target;
    end

    // request decode and state update
    always_comb begin
        n_lens_mode   = r_lens_mode;
        n_key_mode    = r_key_mode;
        n_lens_pos    = r_lens_pos;
        n_lens_target = r_lens_target;
        n_key_pos     = r_key_pos;
        n_key_target  = r_key_target;
        n_drive       = r_drive;
        steps         = 8'd0;
        unique case (r_in_opcode)
            OP_TICK: begin
                if (r_lens_mode) begin
                    n_drive = lens_spd;
                    if (lens_spd == 8'd0) begin
                        if (!r_key_mode) begin
                            steps = {1'b0, r_step_size};
                        end else if (r_key_pos != r_key_target) begin
                            if (!key_diff[15]) begin
                                steps     = {1'b0, r_step_size};
                                n_key_pos = r_key_pos - {9'd0, r_step_size};
                            end else begin
                                steps     = 8'd0 - {1'b0, r_step_size};
                                n_key_pos = r_key_pos + {9'd0, r_step_size};
                            end
                        end
                    end
                end
            end
            OP_BUTTON: begin
                if (r_in_button == BTN_RIGHT) begin
                    if (!r_lens_mode) begin
                        n_lens_mode   = 1'b1;
                        n_lens_target = r_lens_home;
                    end else begin
                        n_lens_pos = 16'd0;
                    end
                    n_drive = 8'd0;
                end else if (r_in_button == BTN_MIDDLE && !r_key_mode) begin
                    n_key_mode   = 1'b1;
                    n_key_target = r_key_home;
                end
            end
            OP_MOVE_REV: begin
                if (r_lens_mode) begin
                    n_lens_pos = r_lens_pos + {8'd0, r_in_amount};
                end
            end
            OP_MOVE_FWD: begin
                if (r_lens_mode) begin
                    n_lens_pos = r_lens_pos - {8'd0, r_in_amount};
                end
            end
            OP_SET_LENS: begin
                n_lens_target = r_in_target;
            end
            OP_SET_KEY: begin
                n_key_target = r_in_target;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance   <= RST_TOLERANCE;
            r_speed_min   <= RST_SPEED_MIN;
            r_speed_max   <= RST_SPEED_MAX;
            r_slow_band   <= RST_SLOW_BAND;
            r_lens_home   <= RST_LENS_HOME;
            r_key_home    <= RST_KEY_HOME;
            r_step_size   <= RST_STEP_SIZE;
            r_ramp_k      <= RST_RAMP_K;
            r_ramp_neg    <= 1'b0;
            r_lens_mode   <= 1'b0;
            r_key_mode    <= 1'b0;
            r_lens_pos    <= 16'd0;
            r_lens_target <= 16'd0;
            r_key_pos     <= 16'd0;
            r_key_target  <= 16'd0;
            r_drive       <= {1'b0, RST_SPEED_MAX};
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_ramp_k   <= n_ramp_k;
            r_ramp_neg <= n_ramp_neg;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TOLERANCE: r_tolerance <= i_cfg_wdata[7:0];
                    CFG_SPEED_MIN: r_speed_min <= i_cfg_wdata[6:0];
                    CFG_SPEED_MAX: begin
                        r_speed_max <= i_cfg_wdata[6:0];
                        if (!r_lens_mode && !process) begin
                            r_drive <= {1'b0, i_cfg_wdata[6:0]};
                        end
                    end
                    CFG_SLOW_BAND: r_slow_band <= i_cfg_wdata[6:0];
                    CFG_LENS_HOME: r_lens_home <= i_cfg_wdata;
                    CFG_KEY_HOME:  r_key_home  <= i_cfg_wdata;
                    CFG_STEP_SIZE: r_step_size <= i_cfg_wdata[6:0];
                    default: begin
                    end
                endcase
            end
            if (process) begin
                r_lens_mode   <= n_lens_mode;
                r_key_mode    <= n_key_mode;
                r_lens_pos    <= n_lens_pos;
                r_lens_target <= n_lens_target;
                r_key_pos     <= n_key_pos;
                r_key_target  <= n_key_target;
                r_drive       <= n_drive;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_opcode <= i_s_axis_tuser;
            r_in_button <= i_s_axis_tdata[1:0];
            r_in_amount <= i_s_axis_tdata[9:2];
            r_in_target <= i_s_axis_tdata[25:10];
        end
        if (process) begin
            r_out_drive    <= n_drive;
            r_out_steps    <= steps;
            r_out_lens_run <= n_lens_mode;
            r_out_key_run  <= n_key_mode;
            r_out_lens_pos <= n_lens_pos;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_lens_pos, r_out_key_run, r_out_lens_run,
                              r_out_steps, r_out_drive};

    `LKPC_ASSERT_NEXT(a_lens_mode_sticky, r_lens_mode, r_lens_mode)
    `LKPC_ASSERT_NEXT(a_in_request_held, r_in_valid && !advance, r_in_valid)
    `LKPC_ASSERT_SAME(a_steps_only_idle, r_out_valid && r_out_steps != 8'd0,
                      r_out_drive == 8'd0)

endmodule

`default_nettype wire

>>> tb/lens_and_keystone_position_control_tb.sv
// ----------------------------------------------------------------------------
// Lens and keystone position control testbench
// Streams directed and random requests through the block under bursty input
// and a stalling output, predicts every status result from its own copy of
// the lens and keystone state, and compares each result field by field.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lens_and_keystone_position_control_tb;
    import lkpc_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic [1:0] BTN_NONE   = 2'd3;
    localparam int STALL_LIMIT        = 4000;
    localparam int PHASE_REQUESTS     = 225;

    typedef struct packed {
        logic [5:0]  padding;
        logic [15:0] lens_position;
        logic        keystone_running;
        logic        lens_running;
        logic [7:0]  stepper_steps;
        logic [7:0]  motor_drive;
    } t_lkpc_status;

    class lkpc_scoreboard;
        logic [7:0]   tolerance;
        logic [6:0]   speed_min, speed_max, slow_band, step_size;
        logic [15:0]  lens_home, key_home;
        logic         lens_homed, key_homed;
        logic [15:0]  lens_pos, lens_target, key_pos, key_target;
        logic [7:0]   drive_level;
        t_lkpc_status expected_status[$];
        int           mismatches;

        function new();
            tolerance   = RST_TOLERANCE;
            speed_min   = RST_SPEED_MIN;
            speed_max   = RST_SPEED_MAX;
            slow_band   = RST_SLOW_BAND;
            lens_home   = RST_LENS_HOME;
            key_home    = RST_KEY_HOME;
            step_size   = RST_STEP_SIZE;
            lens_homed  = 1'b0;
            key_homed   = 1'b0;
            lens_pos    = 16'd0;
            lens_target = 16'd0;
            key_pos     = 16'd0;
            key_target  = 16'd0;
            drive_level = {1'b0, RST_SPEED_MAX};
            mismatches  = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] value);
            case (idx)
                CFG_TOLERANCE: tolerance = value[7:0];
                CFG_SPEED_MIN: speed_min = value[6:0];
                CFG_SPEED_MAX: begin
                    speed_max = value[6:0];
                    if (!lens_homed)
                        drive_level = {1'b0, value[6:0]};
                end
                CFG_SLOW_BAND: slow_band = value[6:0];
                CFG_LENS_HOME: lens_home = value;
                CFG_KEY_HOME:  key_home  = value;
                CFG_STEP_SIZE: step_size = value[6:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] lens_speed();
            logic [15:0] diff, mag;
            int span, spd;
            diff = lens_pos - lens_target;
            mag  = diff[15] ? 16'd0 - diff : diff;
            span = int'(mag);
            if (span <= int'(tolerance))
                spd = 0;
            else if (span <= int'(slow_band))
                spd = int'(speed_min);
            else if (span > int'(FAR_DISTANCE))
                spd = int'(speed_max);
            else
                spd = int'(speed_min) +
                      (span * (int'(speed_max) - int'(speed_min))) / int'(FAR_DISTANCE);
            if (diff[15])
                spd = -spd;
            return 8'(spd);
        endfunction

        function void note_request(logic [2:0] op, logic [1:0] btn, logic [7:0] amt,
                                   logic [15:0] tpos);
            logic [7:0]   steps;
            logic [15:0]  kd;
            t_lkpc_status st;
            steps = 8'd0;
            case (op)
                OP_TICK: begin
                    if (lens_homed) begin
                        drive_level = lens_speed();
                        if (drive_level == 8'd0) begin
                            if (!key_homed) begin
                                steps = {1'b0, step_size};
                            end else if (key_pos != key_target) begin
                                kd = key_pos - key_target;
                                if (!kd[15]) begin
                                    steps   = {1'b0, step_size};
                                    key_pos = key_pos - {9'd0, step_size};
                                end else begin
                                    steps   = 8'd0 - {1'b0, step_size};
                                    key_pos = key_pos + {9'd0, step_size};
                                end
                            end
                        end
                    end
                end
                OP_BUTTON: begin
                    if (btn == BTN_RIGHT) begin
                        if (!lens_homed) begin
                            lens_homed  = 1'b1;
                            lens_target = lens_home;
                        end else begin
                            lens_pos = 16'd0;
                        end
                        drive_level = 8'd0;
                    end else if (btn == BTN_MIDDLE && !key_homed) begin
                        key_homed  = 1'b1;
                        key_target = key_home;
                    end
                end
                OP_MOVE_REV: if (lens_homed) lens_pos = lens_pos + {8'd0, amt};
                OP_MOVE_FWD: if (lens_homed) lens_pos = lens_pos - {8'd0, amt};
                OP_SET_LENS: lens_target = tpos;
                OP_SET_KEY:  key_target  = tpos;
                default: ;
            endcase
            st.padding          = 6'd0;
            st.lens_position    = lens_pos;
            st.keystone_running = key_homed;
            st.lens_running     = lens_homed;
            st.stepper_steps    = steps;
            st.motor_drive      = drive_level;
            expected_status.push_back(st);
        endfunction

        function void report(string field, logic [15:0] exp_val, logic [15:0] act_val);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", field, exp_val, act_val);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            t_lkpc_status exp_st, act_st;
            act_st = data;
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0h", data);
                return;
            end
            exp_st = expected_status.pop_front();
            if (act_st.motor_drive != exp_st.motor_drive)
                report("motor_drive", 16'(exp_st.motor_drive), 16'(act_st.motor_drive));
            if (act_st.stepper_steps != exp_st.stepper_steps)
                report("stepper_steps", 16'(exp_st.stepper_steps),
                       16'(act_st.stepper_steps));
            if (act_st.lens_running !== exp_st.lens_running)
                report("lens_running", 16'(exp_st.lens_running), 16'(act_st.lens_running));
            if (act_st.keystone_running !== exp_st.keystone_running)
                report("keystone_running", 16'(exp_st.keystone_running),
                       16'(act_st.keystone_running));
            if (act_st.lens_position != exp_st.lens_position)
                report("lens_position", exp_st.lens_position, act_st.lens_position);
            if (act_st.padding != exp_st.padding)
                report("padding", 16'(exp_st.padding), 16'(act_st.padding));
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    // button[1:0], move_amount[9:2], target_position[25:10], zero[31:26]
    logic [S_TDATA_W-1:0] i_s_axis_tdata;
    // opcode[2:0]
    logic [S_TUSER_W-1:0] i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    // motor_drive[7:0], stepper_steps[15:8], lens_running[16],
    // keystone_running[17], lens_position[33:18], zero[39:34]
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 i_cfg_we;
    logic [CFG_AW-1:0]    i_cfg_addr;
    logic [CFG_DW-1:0]    i_cfg_wdata;

    lkpc_scoreboard sb;
    int burst_left;
    int ready_run;

    lens_and_keystone_position_control dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // check results, then pick the next ready level from the stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata);
        if (ready_run > 0) begin
            ready_run--;
        end else begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    i_m_axis_tready <= 1'b1;
                    ready_run = $urandom_range(40, 80);
                end
                2, 3, 4, 5: begin
                    i_m_axis_tready <= 1'b1;
                    ready_run = $urandom_range(0, 6);
                end
                default: begin
                    i_m_axis_tready <= 1'b0;
                    ready_run = $urandom_range(0, 6);
                end
            endcase
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_request(logic [2:0] op, logic [1:0] btn, logic [7:0] amt,
                                logic [15:0] tpos);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {6'd0, tpos, amt, btn};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.note_request(op, btn, amt, tpos);
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_random_request();
        logic [2:0]  op;
        logic [1:0]  btn;
        logic [7:0]  amt;
        logic [15:0] tpos, diff, mag;
        int          pick;
        op   = OP_TICK;
        btn  = 2'($urandom);
        amt  = 8'($urandom);
        tpos = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            op = OP_TICK;
        end else if (pick < 62) begin
            // steer the lens towards its target most of the time
            diff = sb.lens_pos - sb.lens_target;
            if ($urandom_range(0, 9) < 7) begin
                op  = diff[15] ? OP_MOVE_REV : OP_MOVE_FWD;
                mag = diff[15] ? 16'd0 - diff : diff;
                if (mag < 16'd256)
                    amt = $urandom_range(0, 1) ? mag[7:0] : 8'($urandom_range(0, int'(mag)));
            end else begin
                op = $urandom_range(0, 1) ? OP_MOVE_REV : OP_MOVE_FWD;
            end
        end else if (pick < 76) begin
            op = OP_SET_LENS;
            if ($urandom_range(0, 4) != 0)
                tpos = sb.lens_pos + 16'($urandom_range(0, 300)) - 16'd150;
        end else if (pick < 86) begin
            op = OP_SET_KEY;
            if ($urandom_range(0, 4) != 0)
                tpos = sb.key_pos + 16'($urandom_range(0, 400)) - 16'd200;
        end else if (pick < 96) begin
            op = OP_BUTTON;
        end else begin
            op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        send_request(op, btn, amt, tpos);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    // hold the input idle until every result is back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [7:0] tol, logic [6:0] smin, logic [6:0] smax,
                             logic [6:0] band, logic [15:0] lhome, logic [15:0] khome,
                             logic [6:0] step, int count);
        logic [15:0] junk;
        drain();
        junk = 16'($urandom);
        write_reg(CFG_TOLERANCE, {junk[15:8], tol});
        write_reg(CFG_SPEED_MIN, {junk[15:7], smin});
        write_reg(CFG_SPEED_MAX, {junk[15:7], smax});
        write_reg(CFG_SLOW_BAND, {junk[15:7], band});
        write_reg(CFG_LENS_HOME, lhome);
        write_reg(CFG_KEY_HOME, khome);
        write_reg(CFG_STEP_SIZE, {junk[15:7], step});
        i_cfg_we <= 1'b0;
        repeat (count) send_random_request();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= '0;
        i_cfg_wdata     <= '0;
        sb         = new();
        burst_left = 0;
        ready_run  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // speed_max before homing moves the drive level
        run_phase(8'd2, 7'd35, 7'd127, 7'd20, 16'h8000, 16'h7FFF, 7'd5, 0);
        send_request(OP_TICK, BTN_RIGHT, 8'd0, 16'd0);
        send_request(OP_MOVE_REV, BTN_LEFT, 8'd255, 16'hFFFF);
        send_request(OP_MOVE_FWD, BTN_NONE, 8'd0, 16'd0);
        send_request(OP_BUTTON, BTN_LEFT, 8'hFF, 16'hFFFF);
        send_request(OP_BUTTON, BTN_NONE, 8'h00, 16'h0000);
        send_request(OP_SPARE_6, BTN_RIGHT, 8'hFF, 16'hFFFF);
        send_request(OP_SPARE_7, BTN_MIDDLE, 8'hAA, 16'h5555);
        send_request(OP_SET_KEY, BTN_RIGHT, 8'd7, 16'd0);
        send_request(OP_BUTTON, BTN_RIGHT, 8'd0, 16'd0);
        send_request(OP_TICK, BTN_LEFT, 8'd0, 16'd0);
        send_request(OP_SET_LENS, BTN_LEFT, 8'd0, 16'd0);
        send_request(OP_TICK, BTN_LEFT, 8'd0, 16'd0);
        send_request(OP_BUTTON, BTN_MIDDLE, 8'd0, 16'd0);
        send_request(OP_TICK, BTN_LEFT, 8'd0, 16'd0);
        send_request(OP_BUTTON, BTN_MIDDLE, 8'd0, 16'd0);
        send_request(OP_MOVE_REV, BTN_LEFT, 8'd255, 16'd0);
        send_request(OP_TICK, BTN_LEFT, 8'd0, 16'd0);
        send_request(OP_SET_LENS, BTN_LEFT, 8'd0, 16'd205);
        send_request(OP_TICK, BTN_LEFT, 8'd0, 16'd0);
        send_request(OP_SET_LENS, BTN_LEFT, 8'd0, 16'd245);
        send_request(OP_TICK, BTN_LEFT, 8'd0, 16'd0);
        send_request(OP_MOVE_FWD, BTN_LEFT, 8'd255, 16'd0);
        send_request(OP_SET_LENS, BTN_LEFT, 8'd0, 16'h7FFF);
        send_request(OP_TICK, BTN_LEFT, 8'd0, 16'd0);
        send_request(OP_BUTTON, BTN_RIGHT, 8'd0, 16'd0);

        run_phase(8'd2, 7'd35, 7'd80, 7'd20, 16'd300, 16'd200, 7'd5, PHASE_REQUESTS);
        run_phase(8'd0, 7'd0, 7'd127, 7'd0, 16'h7FFF, 16'h8000, 7'd1, PHASE_REQUESTS);
        run_phase(8'd255, 7'd127, 7'd127, 7'd100, 16'h8000, 16'h7FFF, 7'd127,
                  PHASE_REQUESTS);
        run_phase(8'd3, 7'd100, 7'd10, 7'd50, 16'd0, 16'd0, 7'd7, PHASE_REQUESTS);
        run_phase(8'd5, 7'd20, 7'd90, 7'd127, 16'hFFFF, 16'h0001, 7'd0, PHASE_REQUESTS);
        drain();

        if (sb.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/lkpc_pkg.sv
src/lens_and_keystone_position_control.sv
tb/lens_and_keystone_position_control_tb.sv
